[rtl/stbs_pkg.sv]
// ----------------------------------------------------------------------------
// stbs_pkg
// Types and codes shared by the sorted table search unit and its record RAM.
// ----------------------------------------------------------------------------
package stbs_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_SELECT = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_ABSENT = 2'd2,
    STAT_RANGE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SRCH_ADDR,
    ST_SRCH_CMP,
    ST_SELECT
  } state_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] key;
    logic signed [31:0] value;
    logic [5:0]         rank;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] found_key;
    logic signed [31:0] found_value;
    logic [6:0]         count;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] value;
  } rec_t;

endpackage

[rtl/sorted_table_binary_search_unit.sv]
// ----------------------------------------------------------------------------
// sorted_table_binary_search_unit
// Key/value table kept in ascending signed key order in one record RAM.
// Insert shifts larger records up, search bisects the filled range, select
// reads a record by rank.
//
//   channel   ports              transfer
//   request   start, busy, req   start high while busy low
//   result    done, rsp          done high for one cycle
//
// Insert moves larger records up, one RAM read and write per cycle.
// Search bisects in steps of a RAM read, then a compare; select reads
// one record by rank; full, out of range and unused commands are answered
// from idle. The result is registered and follows in the cycle after the last step.
// Reset empties the table; no clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_unit #(
  parameter int DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  stbs_pkg::req_t req,
  output logic           done,
  output stbs_pkg::rsp_t rsp
);
  import stbs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 7) ? CW : 7;

  state_t               state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        j, j_next;
  logic signed [CW:0]   lo, lo_next;
  logic signed [CW:0]   hi, hi_next;
  logic [AW-1:0]        mid, mid_next;
  logic signed [31:0]   key_r, value_r;
  logic                 done_next;
  rsp_t                 rsp_next;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  rec_t                 mem_wdata, mem_rdata;

  logic [CW-1:0]        count_m1, count_inc, j_m1, j_m2;
  logic [XW-1:0]        count_x, count_inc_x, rank_x;
  logic signed [CW+1:0] sum;
  logic signed [CW:0]   mid_x;
  rec_t                 new_rec;

  assign count_m1    = count - 1'b1;
  assign count_inc   = count + 1'b1;
  assign j_m1        = j - 1'b1;
  assign j_m2        = j - CW'(2);
  assign count_x     = XW'(count);
  assign count_inc_x = XW'(count_inc);
  assign rank_x      = XW'(req.rank);
  assign sum         = {lo[CW], lo} + {hi[CW], hi};
  assign mid_x       = $signed({{(CW + 1 - AW){1'b0}}, mid});
  assign new_rec     = '{key: key_r, value: value_r};
  assign busy        = (state != ST_IDLE);

  stbs_rec_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    j   <= j_next;
    lo  <= lo_next;
    hi  <= hi_next;
    mid <= mid_next;
    rsp <= rsp_next;
    if (start && !busy) begin
      key_r   <= req.key;
      value_r <= req.value;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    j_next     = j;
    lo_next    = lo;
    hi_next    = hi;
    mid_next   = mid;
    done_next  = 1'b0;
    rsp_next   = rsp;
    mem_we     = 1'b0;
    mem_waddr  = j[AW-1:0];
    mem_wdata  = new_rec;
    mem_raddr  = '0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          rsp_next = '{status: STAT_OK, found_key: '0, found_value: '0,
                       count: count_x[6:0]};
          priority case (req.cmd)
            CMD_INSERT: begin
              if (count == CW'(DEPTH)) begin
                rsp_next.status = STAT_FULL;
                done_next       = 1'b1;
              end else begin
                j_next     = count;
                mem_raddr  = count_m1[AW-1:0];
                state_next = ST_INSERT;
              end
            end
            CMD_SEARCH: begin
              lo_next    = '0;
              hi_next    = $signed({1'b0, count}) - 2'sd1;
              state_next = ST_SRCH_ADDR;
            end
            CMD_SELECT: begin
              if (rank_x < count_x) begin
                mem_raddr  = rank_x[AW-1:0];
                state_next = ST_SELECT;
              end else begin
                rsp_next.status = STAT_RANGE;
                done_next       = 1'b1;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      ST_INSERT: begin
        mem_we    = 1'b1;
        mem_waddr = j[AW-1:0];
        if (j != '0 && key_r < mem_rdata.key) begin
          mem_wdata = mem_rdata;
          j_next    = j_m1;
          mem_raddr = j_m2[AW-1:0];
        end else begin
          mem_wdata      = new_rec;
          count_next     = count_inc;
          rsp_next.count = count_inc_x[6:0];
          done_next      = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      ST_SRCH_ADDR: begin
        if (lo > hi) begin
          rsp_next.status = STAT_ABSENT;
          done_next       = 1'b1;
          state_next      = ST_IDLE;
        end else begin
          mid_next   = sum[AW:1];
          mem_raddr  = sum[AW:1];
          state_next = ST_SRCH_CMP;
        end
      end

      ST_SRCH_CMP: begin
        if (mem_rdata.key == key_r) begin
          rsp_next.found_key   = mem_rdata.key;
          rsp_next.found_value = mem_rdata.value;
          done_next            = 1'b1;
          state_next           = ST_IDLE;
        end else if (lo == hi) begin
          rsp_next.status = STAT_ABSENT;
          done_next       = 1'b1;
          state_next      = ST_IDLE;
        end else begin
          if (key_r < mem_rdata.key) begin
            hi_next = mid_x - 2'sd1;
          end else begin
            lo_next = mid_x + 2'sd1;
          end
          state_next = ST_SRCH_ADDR;
        end
      end

      ST_SELECT: begin
        rsp_next.found_key   = mem_rdata.key;
        rsp_next.found_value = mem_rdata.value;
        done_next            = 1'b1;
        state_next           = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/stbs_rec_ram.sv]
// ----------------------------------------------------------------------------
// stbs_rec_ram
// Record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stbs_rec_ram #(
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  stbs_pkg::rec_t                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output stbs_pkg::rec_t                        rdata
);
  import stbs_pkg::*;

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
